// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the scale quantizer rtl.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define SNSS_ASSERT_CLK(label, clk_s, rst_n_s, prop, msg) \
	label: assert property (@(posedge clk_s) disable iff (!rst_n_s) prop) \
		else $error(msg);

// concurrent assertion on the block clock and reset
`define SNSS_ASSERT(label, prop, msg) `SNSS_ASSERT_CLK(label, clk, arst_n, prop, msg)

`endif

// ===== hw/rtl/snss_pkg.sv =====
// ----------------------------------------------------------------------------
// snss_pkg
// Constants, stage payload types and the divider step for the scale quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

package snss_pkg;

	localparam int PC_COUNT      = 12;
	localparam int TOP_NOTE      = 127;
	localparam int REACH         = 6;
	localparam logic [11:0] MASK_RESET = 12'd2741;

	// floor(n / 12) for n in 0..127 as (n * 171) >> 11
	localparam int DIV12_MUL   = 171;
	localparam int DIV12_SHIFT = 11;

	typedef struct packed {
		logic              in_scale;
		logic [6:0]        snapped_note;
		logic              snapped_valid;
		logic              ok;
		logic [3:0]        snap_pc;
		logic [3:0]        snap_oct;
		logic signed [7:0] steps;
	} snss_front_t;

	typedef struct packed {
		logic       in_scale;
		logic [6:0] snapped_note;
		logic       snapped_valid;
		logic       ok;
		logic [3:0] snap_oct;
		logic       neg;
		logic [7:0] n;
		logic [3:0] size;
	} snss_rank_t;

	typedef struct packed {
		logic       in_scale;
		logic [6:0] snapped_note;
		logic       snapped_valid;
		logic       ok;
		logic [3:0] snap_oct;
		logic       neg;
		logic [3:0] size;
		logic [7:0] qq;
		logic [3:0] rr;
	} snss_quot_t;

	typedef struct packed {
		logic       in_scale;
		logic [6:0] snapped_note;
		logic       snapped_valid;
		logic [6:0] stepped_note;
		logic       stepped_valid;
	} snss_res_t;

	// four restoring division steps: returns {quotient nibble, remainder}
	function automatic logic [7:0] div_nibble(input logic [3:0] rem_in,
		input logic [3:0] bits, input logic [3:0] dvs);
		logic [4:0] r;
		logic [3:0] rem;
		logic [3:0] q;
		rem = rem_in;
		q   = '0;
		for (int i = 3; i >= 0; i--) begin
			r = {rem, bits[i]};
			if (r >= {1'b0, dvs}) begin
				r    = r - {1'b0, dvs};
				q[i] = 1'b1;
			end
			rem = r[3:0];
		end
		return {q, rem};
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/snss_if.sv =====
// ----------------------------------------------------------------------------
// snss_if
// Request, result and register write channels of the scale quantizer.
// ----------------------------------------------------------------------------
`default_nettype none

interface snss_in_if;
	logic              valid;
	logic              ready;
	logic [6:0]        note;
	logic signed [7:0] steps;
	modport source(output valid, note, steps, input ready);
	modport sink(input valid, note, steps, output ready);
endinterface

interface snss_out_if;
	logic       valid;
	logic       ready;
	logic       in_scale;
	logic [6:0] snapped_note;
	logic       snapped_valid;
	logic [6:0] stepped_note;
	logic       stepped_valid;
	modport source(output valid, in_scale, snapped_note, snapped_valid, stepped_note,
		stepped_valid, input ready);
	modport sink(input valid, in_scale, snapped_note, snapped_valid, stepped_note,
		stepped_valid, output ready);
endinterface

interface snss_cfg_if;
	logic        valid;
	logic        ready;
	logic [11:0] scale_mask;
	modport source(output valid, scale_mask, input ready);
	modport sink(input valid, scale_mask, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/snss_front.sv =====
// ----------------------------------------------------------------------------
// snss_front
// Splits the note into octave and pitch class, then snaps it to the scale.
// ----------------------------------------------------------------------------
`default_nettype none

module snss_front import snss_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [11:0]       scale_mask,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [6:0]        note,
	input  wire logic signed [7:0] steps,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output snss_front_t            out_data
);

	logic              v_s1;
	logic [6:0]        note_s1;
	logic signed [7:0] steps_s1;
	logic [3:0]        oct_s1;
	logic [3:0]        pc_s1;
	logic              v_s2;
	snss_front_t       data_s2;

	logic              en1;
	logic              en2;
	logic [14:0]       prod;
	logic [3:0]        oct_w;
	logic [6:0]        pc_w;
	logic [23:0]       rot24;
	logic [11:0]       rot;
	logic              found;
	logic signed [3:0] delta;
	logic signed [5:0] spc_w;
	logic [3:0]        spc;
	logic [3:0]        soct;
	logic              empty;
	snss_front_t       nxt;

	assign en2      = !v_s2 || out_ready;
	assign en1      = !v_s1 || en2;
	assign in_ready = en1;

	assign prod  = 15'(note * DIV12_MUL);
	assign oct_w = prod[DIV12_SHIFT +: 4];
	assign pc_w  = note - 7'(oct_w * PC_COUNT);

	// rot[k] tells whether pitch class (pc + k) mod 12 is in the scale
	assign rot24 = {scale_mask, scale_mask} >> pc_s1;
	assign rot   = rot24[11:0];
	assign empty = (scale_mask == '0);

	always_comb begin
		found = 1'b0;
		delta = '0;
		// walk from the far end so that nearer and lower candidates win
		for (int d = REACH; d >= 1; d--) begin
			if (note_s1 <= 7'(TOP_NOTE - d) && rot[4'(d)]) begin
				found = 1'b1;
				delta = 4'(d);
			end
			if (note_s1 >= 7'(d) && rot[4'(PC_COUNT - d)]) begin
				found = 1'b1;
				delta = -4'(d);
			end
		end
		if (rot[0]) begin
			found = 1'b1;
			delta = '0;
		end
	end

	always_comb begin
		spc_w = $signed({2'b00, pc_s1}) + 6'(delta);
		spc   = spc_w[3:0];
		soct  = oct_s1;
		if (spc_w < 0) begin
			spc  = 4'(spc_w + 6'(PC_COUNT));
			soct = oct_s1 - 4'd1;
		end else if (spc_w >= 6'(PC_COUNT)) begin
			spc  = 4'(spc_w - 6'(PC_COUNT));
			soct = oct_s1 + 4'd1;
		end
	end

	always_comb begin
		nxt.in_scale      = empty || rot[0];
		nxt.snapped_valid = empty || found;
		nxt.ok            = found && !empty;
		nxt.snap_pc       = spc;
		nxt.snap_oct      = soct;
		nxt.steps         = steps_s1;
		if (empty) begin
			nxt.snapped_note = note_s1;
		end else if (found) begin
			nxt.snapped_note = note_s1 + 7'(delta);
		end else begin
			nxt.snapped_note = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (en1) v_s1 <= in_valid;
			if (en2) v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			note_s1  <= note;
			steps_s1 <= steps;
			oct_s1   <= oct_w;
			pc_s1    <= pc_w[3:0];
		end
		if (en2) data_s2 <= nxt;
	end

	assign out_valid = v_s2;
	assign out_data  = data_s2;

endmodule

`default_nettype wire

// ===== hw/rtl/snss_rank.sv =====
// ----------------------------------------------------------------------------
// snss_rank
// Ranks the snapped pitch class within the scale and adds the step count.
// ----------------------------------------------------------------------------
`default_nettype none

module snss_rank import snss_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [11:0] scale_mask,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire snss_front_t in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output snss_rank_t       out_data
);

	logic              v_s3;
	snss_rank_t        data_s3;
	logic              en3;
	logic [11:0]       lower;
	logic [3:0]        idx;
	logic [3:0]        size;
	logic signed [8:0] t;
	logic signed [8:0] nn;
	snss_rank_t        nxt;

	assign en3      = !v_s3 || out_ready;
	assign in_ready = en3;

	assign lower = scale_mask & ((12'd1 << in_data.snap_pc) - 12'd1);
	assign idx   = 4'($countones(lower));
	assign size  = 4'($countones(scale_mask));
	assign t     = $signed({5'b00000, idx}) + 9'(in_data.steps);
	// negative totals divide as (size - 1 - t) to get the floor quotient
	assign nn    = $signed({5'b00000, size}) - 9'sd1 - t;

	always_comb begin
		nxt.in_scale      = in_data.in_scale;
		nxt.snapped_note  = in_data.snapped_note;
		nxt.snapped_valid = in_data.snapped_valid;
		nxt.ok            = in_data.ok;
		nxt.snap_oct      = in_data.snap_oct;
		nxt.neg           = t[8];
		nxt.n             = t[8] ? nn[7:0] : t[7:0];
		nxt.size          = size;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) data_s3 <= nxt;
	end

	assign out_valid = v_s3;
	assign out_data  = data_s3;

endmodule

`default_nettype wire

// ===== hw/rtl/snss_div.sv =====
// ----------------------------------------------------------------------------
// snss_div
// Two-stage restoring divider of the step total by the scale size.
// ----------------------------------------------------------------------------
`default_nettype none

module snss_div import snss_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire snss_rank_t in_data,
	output logic            out_valid,
	input  wire logic       out_ready,
	output snss_quot_t      out_data
);

	typedef struct packed {
		snss_rank_t item;
		logic [3:0] qh;
		logic [3:0] rem;
	} div_mid_t;

	logic       v_s4;
	div_mid_t   data_s4;
	logic       v_s5;
	snss_quot_t data_s5;
	logic       en4;
	logic       en5;
	logic [7:0] hi;
	logic [7:0] lo;
	div_mid_t   mid;
	snss_quot_t nxt;

	assign en5      = !v_s5 || out_ready;
	assign en4      = !v_s4 || en5;
	assign in_ready = en4;

	// upper quotient nibble
	assign hi       = div_nibble(4'd0, in_data.n[7:4], in_data.size);
	assign mid.item = in_data;
	assign mid.qh   = hi[7:4];
	assign mid.rem  = hi[3:0];

	// lower quotient nibble
	assign lo = div_nibble(data_s4.rem, data_s4.item.n[3:0], data_s4.item.size);

	always_comb begin
		nxt.in_scale      = data_s4.item.in_scale;
		nxt.snapped_note  = data_s4.item.snapped_note;
		nxt.snapped_valid = data_s4.item.snapped_valid;
		nxt.ok            = data_s4.item.ok;
		nxt.snap_oct      = data_s4.item.snap_oct;
		nxt.neg           = data_s4.item.neg;
		nxt.size          = data_s4.item.size;
		nxt.qq            = {data_s4.qh, lo[7:4]};
		nxt.rr            = lo[3:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (en4) v_s4 <= in_valid;
			if (en5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en4) data_s4 <= mid;
		if (en5) data_s5 <= nxt;
	end

	assign out_valid = v_s5;
	assign out_data  = data_s5;

endmodule

`default_nettype wire

// ===== hw/rtl/snss_place.sv =====
// ----------------------------------------------------------------------------
// snss_place
// Picks the target scale member and octave, builds and range-checks the note.
// ----------------------------------------------------------------------------
`default_nettype none

module snss_place import snss_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic [11:0] scale_mask,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire snss_quot_t  in_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output snss_res_t        out_data
);

	typedef struct packed {
		logic              in_scale;
		logic [6:0]        snapped_note;
		logic              snapped_valid;
		logic              ok;
		logic [3:0]        member;
		logic signed [9:0] octs;
	} place_mid_t;

	logic               v_s6;
	place_mid_t         data_s6;
	logic               v_s7;
	snss_res_t          data_s7;
	logic               en6;
	logic               en7;
	logic signed [8:0]  q;
	logic [3:0]         r;
	logic [3:0]         member;
	place_mid_t         mid;
	logic signed [13:0] res;
	logic               res_ok;
	snss_res_t          nxt;

	assign en7      = !v_s7 || out_ready;
	assign en6      = !v_s6 || en7;
	assign in_ready = en6;

	assign q = in_data.neg ? -$signed({1'b0, in_data.qq}) : $signed({1'b0, in_data.qq});
	assign r = in_data.neg ? (in_data.size - 4'd1 - in_data.rr) : in_data.rr;

	// the r-th set bit of the mask, counting from pitch class 0
	always_comb begin
		member = '0;
		for (int i = 0; i < PC_COUNT; i++) begin
			if (scale_mask[i] &&
				4'($countones(scale_mask & ((12'd1 << i) - 12'd1))) == r) begin
				member = 4'(i);
			end
		end
	end

	always_comb begin
		mid.in_scale      = in_data.in_scale;
		mid.snapped_note  = in_data.snapped_note;
		mid.snapped_valid = in_data.snapped_valid;
		mid.ok            = in_data.ok;
		mid.member        = member;
		mid.octs          = $signed({6'b000000, in_data.snap_oct}) + 10'(q);
	end

	assign res    = 14'(data_s6.octs * PC_COUNT) + $signed({10'b0, data_s6.member});
	assign res_ok = data_s6.ok && res >= 0 && res <= 14'(TOP_NOTE);

	always_comb begin
		nxt.in_scale      = data_s6.in_scale;
		nxt.snapped_note  = data_s6.snapped_note;
		nxt.snapped_valid = data_s6.snapped_valid;
		nxt.stepped_valid = res_ok;
		nxt.stepped_note  = res_ok ? res[6:0] : 7'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (en6) v_s6 <= in_valid;
			if (en7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en6) data_s6 <= mid;
		if (en7) data_s7 <= nxt;
	end

	assign out_valid = v_s7;
	assign out_data  = data_s7;

endmodule

`default_nettype wire

// ===== hw/rtl/scale_note_snap_and_step_top.sv =====
// ----------------------------------------------------------------------------
// scale_note_snap_and_step_top
// Snaps a note to a pitch-class scale and moves it by scale steps.
// ----------------------------------------------------------------------------
// Usage:
//   req carries a note (0..127) and a signed step count; rsp returns one
//   result per request: in-scale flag, snapped note with its valid flag and
//   the stepped note with its valid flag.
//   cfg writes the 12-bit scale mask; it is always ready and must only be
//   written while no request is in flight.
//   The pipeline has 7 register stages, one each for octave split, snap
//   search, rank, two divider halves, member pick and final note build.
//   Throughput is one request per cycle while rsp is ready; the divider by
//   the scale size is split over two pipeline stages so it never blocks.
//   Reset clears all stage valid bits and loads the C major mask.
//   When rsp stalls, each stage holds its request and bubbles ahead of it are
//   filled, so req stays ready until the pipeline is full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module scale_note_snap_and_step_top import snss_pkg::*; (
	input  wire logic   clk,
	input  wire logic   arst_n,
	snss_cfg_if.sink    cfg,
	snss_in_if.sink     req,
	snss_out_if.source  rsp
);

	logic [11:0] mask_q;

	logic        front_valid;
	logic        rank_ready;
	snss_front_t front_data;
	logic        rank_valid;
	logic        div_ready;
	snss_rank_t  rank_data;
	logic        div_valid;
	logic        place_ready;
	snss_quot_t  div_data;
	logic        place_valid;
	snss_res_t   place_data;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= MASK_RESET;
		end else if (cfg.valid && cfg.ready) begin
			mask_q <= cfg.scale_mask;
		end
	end

	snss_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.scale_mask (mask_q),
		.in_valid   (req.valid),
		.in_ready   (req.ready),
		.note       (req.note),
		.steps      (req.steps),
		.out_valid  (front_valid),
		.out_ready  (rank_ready),
		.out_data   (front_data)
	);

	snss_rank u_rank (
		.clk        (clk),
		.arst_n     (arst_n),
		.scale_mask (mask_q),
		.in_valid   (front_valid),
		.in_ready   (rank_ready),
		.in_data    (front_data),
		.out_valid  (rank_valid),
		.out_ready  (div_ready),
		.out_data   (rank_data)
	);

	snss_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rank_valid),
		.in_ready  (div_ready),
		.in_data   (rank_data),
		.out_valid (div_valid),
		.out_ready (place_ready),
		.out_data  (div_data)
	);

	snss_place u_place (
		.clk        (clk),
		.arst_n     (arst_n),
		.scale_mask (mask_q),
		.in_valid   (div_valid),
		.in_ready   (place_ready),
		.in_data    (div_data),
		.out_valid  (place_valid),
		.out_ready  (rsp.ready),
		.out_data   (place_data)
	);

	assign rsp.valid         = place_valid;
	assign rsp.in_scale      = place_data.in_scale;
	assign rsp.snapped_note  = place_data.snapped_note;
	assign rsp.snapped_valid = place_data.snapped_valid;
	assign rsp.stepped_note  = place_data.stepped_note;
	assign rsp.stepped_valid = place_data.stepped_valid;

	`SNSS_ASSERT(a_step_needs_snap, rsp.valid && rsp.stepped_valid |-> rsp.snapped_valid, "stepped note without a snapped note")
	`SNSS_ASSERT(a_in_scale_snaps, rsp.valid && rsp.in_scale |-> rsp.snapped_valid, "in-scale note did not snap")
	`SNSS_ASSERT(a_bad_step_zero, rsp.valid && !rsp.stepped_valid |-> rsp.stepped_note == 7'd0, "invalid stepped note not zero")
	`SNSS_ASSERT(a_front_holds, front_valid && !rank_ready |=> front_valid, "front stage dropped a stalled request")

endmodule

`default_nettype wire
